// ===== design/bta_pkg.sv =====
// Package for the buddy tree allocator: payload structs, item classes,
// status codes and the back-end sequencer states. No dependencies.
package bta_pkg;

   // Widest node index and order field, for the largest supported tree.
   localparam int NODE_IDX_BITS = 11;
   localparam int ORDER_BITS    = 4;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_TOO_BIG  = 2'd1;
   localparam logic [1:0] STATUS_NO_BLOCK = 2'd2;

   typedef enum logic [1:0] {
      KIND_ALLOC,
      KIND_TOO_BIG,
      KIND_FREE,
      KIND_SKIP
   } item_kind_type;

   typedef struct packed {
      logic        action;
      logic [15:0] request_bytes;
      logic [4:0]  free_leaf;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  granted_leaf;
      logic [2:0]  granted_order;
      logic [31:0] alloc_total;
      logic [31:0] free_total;
   } rsp_payload_type;

   typedef struct packed {
      item_kind_type              kind;
      logic [ORDER_BITS-1:0]      order;
      logic [NODE_IDX_BITS-1:0]   node;
   } work_item_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_A_READ,
      ST_A_NODE,
      ST_A_LEFT,
      ST_A_RIGHT,
      ST_A_BACK,
      ST_A_UP,
      ST_F_READ,
      ST_F_CHECK,
      ST_F_CLEAR,
      ST_F_SIB,
      ST_F_SIBCHK
   } back_state_type;

endpackage

// ===== design/bta_interfaces.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on bta_pkg for the payload structs.
interface bta_req_if;
   logic                     valid;
   logic                     ready;
   bta_pkg::req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface bta_rsp_if;
   logic                     valid;
   logic                     ready;
   bta_pkg::rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== design/bta_front.sv =====
// Front end: accepts requests, rounds sizes to an order and finds the
// starting node of a free. Depends on bta_pkg and bta_req_if.
module bta_front #(
   parameter int ORDERS      = 5,
   parameter int BLOCK_BYTES = 64
) (
   bta_req_if.sink                 req,
   output logic                    push_valid,
   input  logic                    push_ready,
   output bta_pkg::work_item_type  push_item
);
   localparam int NW = ORDERS + 1;

   logic [bta_pkg::ORDER_BITS-1:0] order;
   logic                           fits;
   logic [ORDERS-1:0]              leaf;
   logic [bta_pkg::ORDER_BITS-1:0] tz;
   logic [NW-1:0]                  span_base;
   logic [NW-1:0]                  start_node;
   logic                           beyond;

   // Smallest order whose block holds the request; none if too large.
   always_comb begin
      order = '0;
      fits  = 1'b0;
      for (int o = ORDERS; o >= 0; o--) begin
         if (32'(req.payload.request_bytes) <= (32'(BLOCK_BYTES) << o)) begin
            order = bta_pkg::ORDER_BITS'(o);
            fits  = 1'b1;
         end
      end
   end

   // The shallowest node starting at a leaf sits at the order of the
   // offset's lowest set bit.
   always_comb begin
      leaf   = ORDERS'(req.payload.free_leaf);
      beyond = 32'(req.payload.free_leaf) >= (32'(1) << ORDERS);
      tz     = '0;
      for (int i = ORDERS - 1; i >= 0; i--) begin
         if (leaf[i]) begin
            tz = bta_pkg::ORDER_BITS'(i);
         end
      end
      span_base = (NW'(1) << (ORDERS - 32'(tz))) - NW'(1);
      if (leaf == '0) begin
         start_node = '0;
      end else begin
         start_node = span_base + NW'(leaf >> tz);
      end
   end

   always_comb begin
      push_item.order = order;
      push_item.node  = bta_pkg::NODE_IDX_BITS'(start_node);
      if (req.payload.action == 1'b0) begin
         push_item.kind = fits ? bta_pkg::KIND_ALLOC : bta_pkg::KIND_TOO_BIG;
      end else begin
         push_item.kind = beyond ? bta_pkg::KIND_SKIP : bta_pkg::KIND_FREE;
      end
   end

   assign push_valid = req.valid;
   assign req.ready  = push_ready;

endmodule

// ===== design/bta_queue.sv =====
// Two-entry queue of classified work items between front and back.
// Depends on bta_pkg.
module bta_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  bta_pkg::work_item_type  push_item,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output bta_pkg::work_item_type  pop_item
);
   bta_pkg::work_item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== design/bta_back.sv =====
// Back end: walks the mark tree in a memory with one read and one write port to
// allocate and free blocks, keeps the counters and holds the response. Depends on bta_pkg.
module bta_back #(
   parameter int ORDERS = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  bta_pkg::work_item_type  pop_item,
   bta_rsp_if.source               rsp
);
   localparam int NODES = (2 << ORDERS) - 1;
   localparam int NW    = ORDERS + 1;
   localparam int LW    = ORDERS;
   localparam int OW    = $clog2(ORDERS + 1);
   localparam logic [NW-1:0] LEAF_BASE = NW'((1 << ORDERS) - 1);

   bta_pkg::back_state_type state_ff, state_in;
   logic [NW-1:0] node_ff, node_in;
   logic [OW-1:0] cur_ff, cur_in;
   logic [OW-1:0] want_ff, want_in;
   logic [LW-1:0] lo_ff, lo_in;
   logic          mnode_ff, mnode_in;
   logic          mleft_ff, mleft_in;
   logic [NW-1:0] clr_ff, clr_in;
   logic [31:0]   alloc_ff, alloc_in;
   logic [31:0]   free_ff, free_in;
   logic          out_valid_ff, out_valid_in;
   bta_pkg::rsp_payload_type out_ff, out_in;

   logic          marks_mem [NODES];
   logic          rd_data_ff;
   logic [NW-1:0] rd_addr, wr_addr;
   logic          wr_en, wr_data;

   logic          slot_free, is_root, at_want, pruned, internal, out_load;
   logic [NW-1:0] left, right, parent, sib;
   logic [LW-1:0] step;

   assign slot_free = !out_valid_ff || rsp.ready;
   assign is_root   = node_ff == '0;
   assign at_want   = cur_ff == want_ff;
   assign pruned    = mnode_ff && !mleft_ff && !rd_data_ff;
   assign internal  = node_ff < LEAF_BASE;
   assign left      = NW'({node_ff, 1'b1});
   assign right     = left + NW'(1);
   assign parent    = (node_ff - NW'(1)) >> 1;
   assign sib       = node_ff[0] ? node_ff + NW'(1) : node_ff - NW'(1);
   assign step      = LW'(1) << cur_ff;
   assign pop_ready = state_ff == bta_pkg::ST_IDLE && slot_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bta_pkg::ST_CLEAR: begin
            if (clr_ff == NW'(NODES - 1)) state_in = bta_pkg::ST_IDLE;
         end
         bta_pkg::ST_IDLE: begin
            if (pop_valid && slot_free) begin
               if (pop_item.kind == bta_pkg::KIND_ALLOC) begin
                  state_in = bta_pkg::ST_A_READ;
               end else if (pop_item.kind == bta_pkg::KIND_FREE) begin
                  state_in = bta_pkg::ST_F_READ;
               end
            end
         end
         bta_pkg::ST_A_READ: state_in = bta_pkg::ST_A_NODE;
         bta_pkg::ST_A_NODE: begin
            if (at_want) begin
               state_in = rd_data_ff ? bta_pkg::ST_A_BACK : bta_pkg::ST_A_UP;
            end else begin
               state_in = bta_pkg::ST_A_LEFT;
            end
         end
         bta_pkg::ST_A_LEFT: state_in = bta_pkg::ST_A_RIGHT;
         bta_pkg::ST_A_RIGHT: begin
            state_in = pruned ? bta_pkg::ST_A_BACK : bta_pkg::ST_A_READ;
         end
         bta_pkg::ST_A_BACK: begin
            if (is_root) begin
               state_in = bta_pkg::ST_IDLE;
            end else if (node_ff[0]) begin
               state_in = bta_pkg::ST_A_READ;
            end
         end
         bta_pkg::ST_A_UP: begin
            if (is_root) state_in = bta_pkg::ST_IDLE;
         end
         bta_pkg::ST_F_READ: begin
            state_in = internal ? bta_pkg::ST_F_CHECK : bta_pkg::ST_F_CLEAR;
         end
         bta_pkg::ST_F_CHECK: begin
            state_in = rd_data_ff ? bta_pkg::ST_F_READ : bta_pkg::ST_F_CLEAR;
         end
         bta_pkg::ST_F_CLEAR: state_in = bta_pkg::ST_F_SIB;
         bta_pkg::ST_F_SIB: begin
            state_in = is_root ? bta_pkg::ST_IDLE : bta_pkg::ST_F_SIBCHK;
         end
         bta_pkg::ST_F_SIBCHK: begin
            state_in = rd_data_ff ? bta_pkg::ST_IDLE : bta_pkg::ST_F_SIB;
         end
         default: state_in = bta_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      node_in  = node_ff;
      cur_in   = cur_ff;
      want_in  = want_ff;
      lo_in    = lo_ff;
      mnode_in = mnode_ff;
      mleft_in = mleft_ff;
      clr_in   = clr_ff;
      alloc_in = alloc_ff;
      free_in  = free_ff;
      rd_addr  = node_ff;
      wr_en    = 1'b0;
      wr_addr  = node_ff;
      wr_data  = 1'b0;
      out_load = 1'b0;
      out_in.status        = bta_pkg::STATUS_OK;
      out_in.granted_leaf  = '0;
      out_in.granted_order = '0;
      case (state_ff)
         bta_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + NW'(1);
         end
         bta_pkg::ST_IDLE: begin
            node_in = NW'(pop_item.node);
            cur_in  = OW'(ORDERS);
            want_in = OW'(pop_item.order);
            lo_in   = '0;
            if (pop_valid && slot_free) begin
               if (pop_item.kind == bta_pkg::KIND_TOO_BIG) begin
                  out_load      = 1'b1;
                  out_in.status = bta_pkg::STATUS_TOO_BIG;
               end else if (pop_item.kind == bta_pkg::KIND_SKIP) begin
                  out_load = 1'b1;
               end
            end
            if (pop_item.kind == bta_pkg::KIND_ALLOC) node_in = '0;
         end
         bta_pkg::ST_A_READ: rd_addr = node_ff;
         bta_pkg::ST_A_NODE: begin
            mnode_in = rd_data_ff;
            rd_addr  = left;
            if (at_want && !rd_data_ff) begin
               wr_en   = 1'b1;
               wr_data = 1'b1;
            end
         end
         bta_pkg::ST_A_LEFT: begin
            mleft_in = rd_data_ff;
            rd_addr  = right;
         end
         bta_pkg::ST_A_RIGHT: begin
            if (!pruned) begin
               node_in = left;
               cur_in  = cur_ff - OW'(1);
            end
         end
         bta_pkg::ST_A_BACK: begin
            // Leaving a failed subtree: try the right sibling, or climb; at the root report no block.
            if (is_root) begin
               out_load      = 1'b1;
               out_in.status = bta_pkg::STATUS_NO_BLOCK;
            end else if (node_ff[0]) begin
               node_in = node_ff + NW'(1);
               lo_in   = lo_ff + step;
            end else begin
               node_in = parent;
               lo_in   = lo_ff - step;
               cur_in  = cur_ff + OW'(1);
            end
         end
         bta_pkg::ST_A_UP: begin
            if (is_root) begin
               out_load             = 1'b1;
               alloc_in             = alloc_ff + 32'd1;
               out_in.granted_leaf  = 5'(lo_ff);
               out_in.granted_order = 3'(want_ff);
            end else begin
               node_in = parent;
               wr_en   = 1'b1;
               wr_addr = parent;
               wr_data = 1'b1;
            end
         end
         bta_pkg::ST_F_READ: rd_addr = left;
         bta_pkg::ST_F_CHECK: begin
            if (rd_data_ff) node_in = left;
         end
         bta_pkg::ST_F_CLEAR: wr_en = 1'b1;
         bta_pkg::ST_F_SIB: begin
            rd_addr = sib;
            if (is_root) begin
               out_load = 1'b1;
               free_in  = free_ff + 32'd1;
            end
         end
         bta_pkg::ST_F_SIBCHK: begin
            if (rd_data_ff) begin
               out_load = 1'b1;
               free_in  = free_ff + 32'd1;
            end else begin
               node_in = parent;
               wr_en   = 1'b1;
               wr_addr = parent;
            end
         end
         default: begin
         end
      endcase
      out_in.alloc_total = alloc_in;
      out_in.free_total  = free_in;
      out_valid_in = out_load ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bta_pkg::ST_CLEAR;
         clr_ff       <= '0;
         alloc_ff     <= '0;
         free_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         alloc_ff     <= alloc_in;
         free_ff      <= free_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff  <= node_in;
      cur_ff   <= cur_in;
      want_ff  <= want_in;
      lo_ff    <= lo_in;
      mnode_ff <= mnode_in;
      mleft_ff <= mleft_in;
      if (out_load) out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) marks_mem[wr_addr] <= wr_data;
      rd_data_ff <= marks_mem[rd_addr];
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_ff;

endmodule

// ===== design/buddy_tree_allocator_core.sv =====
// Top level of the buddy tree allocator: front end, work queue, back end.
// Depends on bta_pkg, bta_interfaces, bta_front, bta_queue and bta_back.
//
//   channel  direction  handshake      payload
//   req_bus  in         valid / ready  action, request_bytes, free_leaf
//   rsp_bus  out        valid / ready  status, granted_leaf, granted_order,
//                                      alloc_total, free_total
//
// Every request is popped by the back end in its idle state. An allocation then descends
// through the tree, reading each node and both of its children, checks the node at the
// wanted order, and after a failure steps to a sibling or parent. It finishes with a
// marking climb to the root. A free walks the left chain down to the node to clear, clears
// it and then climbs, clearing each parent while the sibling is also clear. The walks are
// sequenced around the single read port of the mark memory. After reset a clearing pass
// writes every node before the first request is served. A new request starts only when
// the response register is empty or being taken; the two-entry queue keeps accepting
// meanwhile until it is full.
module buddy_tree_allocator_core #(
   parameter int ORDERS      = 5,
   parameter int BLOCK_BYTES = 64
) (
   input logic        clock,
   input logic        reset,
   bta_req_if.sink    req_bus,
   bta_rsp_if.source  rsp_bus
);
   logic                   push_valid, push_ready;
   logic                   pop_valid, pop_ready;
   bta_pkg::work_item_type push_item, pop_item;

   bta_front #(
      .ORDERS      (ORDERS),
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_front (
      .req        (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   bta_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   bta_back #(
      .ORDERS (ORDERS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp       (rsp_bus)
   );

endmodule
